[hdl/qbp_pkg.sv]
// Shared types and constants for the QR byte-mode segment packer.
package qbp_pkg;

  // Largest number of data codewords the packer will ever count
  localparam logic [11:0] MAX_CODEWORDS = 12'd4095;

  // Versions from this one on use the 16-bit character count
  localparam logic [5:0] WIDE_COUNT_VERSION = 6'd10;

  // Mode indicator and pad codewords
  localparam logic [3:0] MODE_BYTE = 4'b0100;
  localparam logic [7:0] PAD_FIRST = 8'hEC;
  localparam logic [7:0] PAD_SECOND = 8'h11;

  // Reset values of the configuration registers
  localparam logic [5:0] VERSION_RESET = 6'd1;
  localparam logic [11:0] CAPACITY_RESET = 12'd19;

  // Command queue geometry
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Field widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMD_BITS_W = 20;
  localparam int CMD_COUNT_W = 5;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_DATA = 2'd1,
    KIND_FINALIZE = 2'd2,
    KIND_PAD = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_VERSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY_BYTES = 2'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_CAPACITY = 2'd2;

  // One configuration write beat
  typedef struct packed {
    logic valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Bit-append command handed from the classifier to the packer
  typedef struct packed {
    logic [CMD_BITS_W-1:0] bits;   // right-aligned bits to append
    logic [CMD_COUNT_W-1:0] count; // number of bits, unused when finalize
    logic flag_drop;               // dropped bits set the overflow flag
    logic finalize;                // terminator plus byte alignment
  } cmd_t;

endpackage

[hdl/qbp_front.sv]
// Front end: classifies input items into bit-append commands.
module qbp_front (
  input  logic clk,
  input  logic rst,
  input  qbp_pkg::cfg_wr_t cfg_wr,
  input  logic accept,
  input  logic [1:0] kind,
  input  logic [15:0] value,
  output qbp_pkg::cmd_t cmd
);
  import qbp_pkg::*;

  logic [5:0] symbol_version;
  logic pad_toggle;
  logic pad_toggle_next;

  // Capture the symbol version register
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_version <= VERSION_RESET;
    end else if (cfg_wr.valid && cfg_wr.index == REG_SYMBOL_VERSION) begin
      symbol_version <= cfg_wr.data[5:0];
    end
  end

  // Build the command for the current item
  always_comb begin
    cmd = '0;
    pad_toggle_next = pad_toggle;
    case (kind_t'(kind))
      KIND_SEGMENT: begin
        cmd.flag_drop = 1'b1;
        if (symbol_version < WIDE_COUNT_VERSION) begin
          cmd.bits = {8'd0, MODE_BYTE, value[7:0]};
          cmd.count = 5'd12;
        end else begin
          cmd.bits = {MODE_BYTE, value};
          cmd.count = 5'd20;
        end
      end
      KIND_DATA: begin
        cmd.flag_drop = 1'b1;
        cmd.bits = {12'd0, value[7:0]};
        cmd.count = 5'd8;
      end
      KIND_FINALIZE: begin
        cmd.finalize = 1'b1;
        pad_toggle_next = 1'b0;
      end
      KIND_PAD: begin
        cmd.flag_drop = 1'b1;
        cmd.bits = {12'd0, (pad_toggle ? PAD_SECOND : PAD_FIRST)};
        cmd.count = 5'd8;
        pad_toggle_next = ~pad_toggle;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Advance the pad alternation on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_toggle <= 1'b0;
    end else if (accept) begin
      pad_toggle <= pad_toggle_next;
    end
  end

endmodule

[hdl/qbp_cmd_fifo.sv]
// Short command queue between the classifier and the packer.
module qbp_cmd_fifo (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  qbp_pkg::cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output qbp_pkg::cmd_t rd_cmd,
  output logic rd_avail
);
  import qbp_pkg::*;

  cmd_t entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] fill;

  assign full = (fill == CMD_CNT_W'(CMD_DEPTH));
  assign rd_avail = (fill != '0);
  assign rd_cmd = entries[rd_ptr];

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_avail)
    else $error("command queue read while empty");

endmodule

[hdl/qbp_back.sv]
// Back end: packs command bits into codewords and presents the results.
module qbp_back (
  input  logic clk,
  input  logic rst,
  input  qbp_pkg::cfg_wr_t cfg_wr,
  input  logic cmd_avail,
  input  qbp_pkg::cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output logic [7:0] codeword,
  output logic codeword_valid,
  output logic last,
  output logic [1:0] status
);
  import qbp_pkg::*;

  // Configuration and packing state
  logic [11:0] capacity_bytes;
  logic [7:0] bit_accumulator;
  logic [2:0] bits_pending;
  logic [11:0] bytes_written;
  logic overflow_seen;

  // Result hold register
  logic hold_valid;
  logic [7:0] hold_byte [3];
  logic [1:0] hold_last_idx;
  logic [1:0] hold_idx;
  logic [1:0] hold_status;
  logic hold_cw_valid;

  // Packing datapath
  logic [11:0] eff_cap;
  logic [CMD_COUNT_W-1:0] count;
  logic [4:0] n_bits;
  logic [1:0] n_full;
  logic [26:0] stream;
  logic [31:0] aligned;
  logic at_cap;
  logic [11:0] room;
  logic limited;
  logic [1:0] n_emit;
  logic dropped;
  logic [7:0] acc_next;
  logic [2:0] pending_next;
  logic [11:0] written_next;
  logic overflow_next;
  logic [1:0] status_next;

  // Handshake
  logic take;
  logic drain_last;
  logic load;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes <= CAPACITY_RESET;
    end else if (cfg_wr.valid && cfg_wr.index == REG_CAPACITY_BYTES) begin
      capacity_bytes <= cfg_wr.data[11:0];
    end
  end

  // Line up the pending bits with the new bits, MSB first
  always_comb begin
    eff_cap = (capacity_bytes > MAX_CODEWORDS) ? MAX_CODEWORDS : capacity_bytes;
    if (cmd.finalize) begin
      count = (bits_pending <= 3'd4) ? (5'd8 - {2'b0, bits_pending})
                                     : (5'd16 - {2'b0, bits_pending});
    end else begin
      count = cmd.count;
    end
    n_bits = {2'b0, bits_pending} + count;
    n_full = n_bits[4:3];
    stream = ({19'd0, bit_accumulator} << count) |
             {7'd0, (cmd.finalize ? {CMD_BITS_W{1'b0}} : cmd.bits)};
    aligned = {5'd0, stream} << (6'd32 - {1'b0, n_bits});
  end

  // Limit the emitted bytes to the room left and work out the new state
  always_comb begin
    at_cap = (bytes_written >= eff_cap);
    room = eff_cap - bytes_written;
    limited = !at_cap && (room <= {10'd0, n_full});
    acc_next = bit_accumulator;
    pending_next = bits_pending;
    n_emit = 2'd0;
    dropped = 1'b0;
    if (at_cap) begin
      dropped = (count != '0);
    end else if (limited) begin
      n_emit = room[1:0];
      acc_next = 8'd0;
      pending_next = 3'd0;
      dropped = (n_bits != {room[1:0], 3'b000});
    end else begin
      n_emit = n_full;
      pending_next = n_bits[2:0];
      acc_next = stream[7:0] & ~(8'hFF << n_bits[2:0]);
    end
    written_next = bytes_written + {10'd0, n_emit};
    overflow_next = overflow_seen | (cmd.flag_drop & dropped);
    if (overflow_next) begin
      status_next = STATUS_OVERFLOW;
    end else if (written_next >= eff_cap) begin
      status_next = STATUS_CAPACITY;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // Load a new command once the hold register drains
  assign take = pop && hold_valid;
  assign drain_last = take && (hold_idx == hold_last_idx);
  assign load = cmd_avail && (!hold_valid || drain_last);
  assign cmd_take = load;

  // Update packing state per loaded command
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= 8'd0;
      bits_pending <= 3'd0;
      bytes_written <= 12'd0;
      overflow_seen <= 1'b0;
    end else if (load) begin
      bit_accumulator <= acc_next;
      bits_pending <= pending_next;
      bytes_written <= written_next;
      overflow_seen <= overflow_next;
    end
  end

  // Track hold occupancy and the result being shown
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_idx <= 2'd0;
    end else if (load) begin
      hold_valid <= 1'b1;
      hold_idx <= 2'd0;
    end else if (drain_last) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_idx <= hold_idx + 2'd1;
    end
  end

  // Capture the codewords of the loaded command
  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte[0] <= (n_emit == 2'd0) ? 8'd0 : aligned[31:24];
      hold_byte[1] <= aligned[23:16];
      hold_byte[2] <= aligned[15:8];
      hold_last_idx <= (n_emit == 2'd0) ? 2'd0 : n_emit - 2'd1;
      hold_cw_valid <= (n_emit != 2'd0);
      hold_status <= status_next;
    end
  end

  // Drive the result ports from the hold register
  always_comb begin
    case (hold_idx)
      2'd0: codeword = hold_byte[0];
      2'd1: codeword = hold_byte[1];
      2'd2: codeword = hold_byte[2];
      default: codeword = 8'd0;
    endcase
  end

  assign empty = !hold_valid;
  assign codeword_valid = hold_cw_valid;
  assign last = (hold_idx == hold_last_idx);
  assign status = hold_status;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> hold_idx <= hold_last_idx)
    else $error("result index past last codeword");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !hold_cw_valid) |-> (hold_last_idx == 2'd0 && codeword == 8'd0))
    else $error("step without codeword must give one zero result");

  a_load_on_drain: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !drain_last) |-> !load)
    else $error("command loaded over undelivered results");

endmodule

[hdl/qr_byte_mode_segment_packer_unit.sv]
// An accepted item passes through the command queue into the result hold register.
// One item per cycle while each item yields one result (data bytes) and pop stays high;
// an item that completes two or three codewords holds the packer until all are popped.
// A four-entry command queue lets the input side run ahead while results wait.
// Reset (synchronous, active high) empties the queue and result register, clears
// the packing state and restores version 1 and a capacity of 19 codewords.
module qr_byte_mode_segment_packer_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] kind,
  input  logic [15:0] value,
  output logic empty,
  input  logic pop,
  output logic [7:0] codeword,
  output logic codeword_valid,
  output logic last,
  output logic [1:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [qbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qbp_pkg::*;

  cfg_wr_t cfg_wr;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic accept;
  logic queue_avail;
  logic queue_take;

  // Configuration writes are taken in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data = cfg_data;

  assign accept = push && !full;

  qbp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .accept (accept),
    .kind   (kind),
    .value  (value),
    .cmd    (front_cmd)
  );

  qbp_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_en    (queue_take),
    .rd_cmd   (queue_cmd),
    .rd_avail (queue_avail)
  );

  qbp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_wr),
    .cmd_avail      (queue_avail),
    .cmd            (queue_cmd),
    .cmd_take       (queue_take),
    .empty          (empty),
    .pop            (pop),
    .codeword       (codeword),
    .codeword_valid (codeword_valid),
    .last           (last),
    .status         (status)
  );

endmodule

[verif/qr_byte_mode_segment_packer_unit_tb.sv]
// Self-checking testbench for the QR byte-mode segment packer unit.
`timescale 1ns / 100ps

module qr_byte_mode_segment_packer_unit_tb;
  import qbp_pkg::*;

  localparam int RAND_ITEMS = 265;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTED = 30;
  localparam int DIR_ROWS = 29;

  // Index codes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_CAP_REL
  } row_op_t;

  typedef enum logic [1:0] {
    SHAPE_PLAIN,
    SHAPE_HEADLESS,
    SHAPE_NOISE,
    SHAPE_MIDPAD
  } msg_shape_t;

  typedef struct packed {
    logic [7:0] cw;
    logic vld;
    logic lst;
    logic [1:0] st;
  } cw_result_t;

  typedef struct packed {
    row_op_t op;
    logic [1:0] sel;
    logic [15:0] val;
    logic typed;
    cw_result_t res;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] k;
    logic [15:0] v;
  } item_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic [1:0] kind;
  logic [15:0] value;
  logic empty;
  logic pop;
  logic [7:0] codeword;
  logic codeword_valid;
  logic last;
  logic [1:0] status;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Packer model state
  logic [5:0] sym_version;
  logic [11:0] cap_words;
  logic [7:0] acc_bits;
  logic [2:0] acc_count;
  logic [11:0] words_done;
  logic pad_phase;
  logic dropped_flag;
  logic [7:0] step_words[$];

  cw_result_t due_words[$];
  item_t msg[$];
  stim_row_t dir_rows[DIR_ROWS];

  int err_count = 0;
  int n_items = 0;
  int n_directed = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_cap_status = 0;
  int n_ovf_status = 0;
  int n_blank = 0;
  int n_multi = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int hold_req_count = 0;

  qr_byte_mode_segment_packer_unit u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .value(value),
    .empty(empty),
    .pop(pop),
    .codeword(codeword),
    .codeword_valid(codeword_valid),
    .last(last),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [11:0] usable_cap();
    return (cap_words > MAX_CODEWORDS) ? MAX_CODEWORDS : cap_words;
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Shift bits into the accumulator MSB first; drop whatever lies past capacity
  function automatic void append_bits(input logic [19:0] bits, input int count,
                                      input bit flag_drop);
    for (int i = count - 1; i >= 0; i--) begin
      if (words_done >= usable_cap()) begin
        if (flag_drop) dropped_flag = 1'b1;
      end else begin
        acc_bits = {acc_bits[6:0], bits[i]};
        if (acc_count == 3'd7) begin
          step_words.push_back(acc_bits);
          words_done = words_done + 12'd1;
          acc_count = 3'd0;
          acc_bits = 8'h00;
        end else begin
          acc_count = acc_count + 3'd1;
        end
      end
    end
  endfunction

  // Advance the packer model by one item and queue the codewords it completes
  function automatic void pack_item(input logic [1:0] k, input logic [15:0] v,
                                    input bit typed, input cw_result_t typed_res);
    cw_result_t r;
    logic [1:0] st;
    step_words.delete();
    case (kind_t'(k))
      KIND_SEGMENT: begin
        append_bits({16'd0, MODE_BYTE}, 4, 1'b1);
        if (sym_version < WIDE_COUNT_VERSION) append_bits({12'd0, v[7:0]}, 8, 1'b1);
        else append_bits({4'd0, v}, 16, 1'b1);
      end
      KIND_DATA: append_bits({12'd0, v[7:0]}, 8, 1'b1);
      KIND_FINALIZE: begin
        append_bits(20'd0, 4, 1'b0);
        if (acc_count != 3'd0) append_bits(20'd0, 8 - acc_count, 1'b0);
        pad_phase = 1'b0;
      end
      default: begin
        append_bits({12'd0, pad_phase ? PAD_SECOND : PAD_FIRST}, 8, 1'b1);
        pad_phase = ~pad_phase;
      end
    endcase
    if (dropped_flag) st = STATUS_OVERFLOW;
    else if (words_done >= usable_cap()) st = STATUS_CAPACITY;
    else st = STATUS_OK;
    if (step_words.size() > 1) n_multi++;
    if (typed) begin
      due_words.push_back(typed_res);
    end else if (step_words.size() == 0) begin
      r.cw = 8'h00;
      r.vld = 1'b0;
      r.lst = 1'b1;
      r.st = st;
      due_words.push_back(r);
    end else begin
      foreach (step_words[i]) begin
        r.cw = step_words[i];
        r.vld = 1'b1;
        r.lst = (i == step_words.size() - 1);
        r.st = st;
        due_words.push_back(r);
      end
    end
  endfunction

  // Codewords a message completes from the current bit position
  function automatic int bytes_for_message(input bit skip_last_fin);
    int tot;
    int cnt;
    tot = acc_count;
    cnt = skip_last_fin ? msg.size() - 1 : msg.size();
    for (int i = 0; i < cnt; i++) begin
      case (kind_t'(msg[i].k))
        KIND_SEGMENT: tot += (sym_version < WIDE_COUNT_VERSION) ? 12 : 20;
        KIND_FINALIZE: begin
          tot += 4;
          if (tot % 8 != 0) tot += 8 - tot % 8;
        end
        default: tot += 8;
      endcase
    end
    return (tot + 7) / 8;
  endfunction

  function automatic void add_item(input kind_t k, input logic [15:0] v);
    item_t it;
    it.k = k;
    it.v = v;
    msg.push_back(it);
  endfunction

  // Build one message: header, data bytes, finalize, pads, or a broken variant
  function automatic void build_message(input msg_shape_t shape, input int n_data);
    int n;
    n = n_data;
    if (n < 0) n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
    msg.delete();
    case (shape)
      SHAPE_PLAIN: begin
        add_item(KIND_SEGMENT, rand_word());
        repeat (n) add_item(KIND_DATA, rand_word());
        add_item(KIND_FINALIZE, rand_word());
        repeat ($urandom_range(0, 4)) add_item(KIND_PAD, rand_word());
      end
      SHAPE_HEADLESS: begin
        repeat (n) add_item(KIND_DATA, rand_word());
        if ($urandom_range(0, 1) == 1) add_item(KIND_FINALIZE, rand_word());
      end
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 8)) add_item(kind_t'($urandom_range(0, 3)), rand_word());
      end
      default: begin
        add_item(KIND_SEGMENT, rand_word());
        repeat (n / 2) add_item(KIND_DATA, rand_word());
        add_item(KIND_PAD, rand_word());
        repeat (n - n / 2) add_item(KIND_DATA, rand_word());
        add_item(KIND_FINALIZE, rand_word());
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one item; the sender runs in bursts with random gaps between them
  task automatic send_item(input logic [1:0] k, input logic [15:0] v, input bit typed,
                           input cw_result_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
        cfg_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    kind <= k;
    value <= v;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);
    pack_item(k, v, typed, typed_res);
    n_items++;
  endtask

  task automatic send_message();
    foreach (msg[i]) send_item(msg[i].k, msg[i].v, 1'b0, '0);
  endtask

  // Drop push and wait for every expected codeword to drain
  task automatic settle_block();
    @(negedge clk);
    push <= 1'b0;
    cfg_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    settle_block();
    @(negedge clk);
    push <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SYMBOL_VERSION) sym_version = data[5:0];
    else if (idx == REG_CAPACITY_BYTES) cap_words = data[11:0];
    n_writes++;
  endtask

  // Check each popped beat against the oldest expected codeword
  always @(posedge clk) begin : check_results
    cw_result_t want;
    if (!rst && pop && !empty) begin
      n_results++;
      if (status == STATUS_CAPACITY) n_cap_status++;
      if (status == STATUS_OVERFLOW) n_ovf_status++;
      if (codeword_valid === 1'b0) n_blank++;
      if (due_words.size() == 0) begin
        report_mismatch("result with nothing pending, codeword", codeword, 0);
      end else begin
        want = due_words.pop_front();
        if (codeword !== want.cw) report_mismatch("codeword", codeword, want.cw);
        if (codeword_valid !== want.vld)
          report_mismatch("codeword_valid", codeword_valid, want.vld);
        if (last !== want.lst) report_mismatch("last", last, want.lst);
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("qr_byte_mode_segment_packer_unit verification failed");
        $finish;
      end
    end
  end

  // Receiver: stall on changing duty cycles, plus one long hold on request
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    int holds_served;
    pop = 1'b0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_req_count != holds_served) begin
        holds_served = hold_req_count;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Main sequence
  initial begin
    logic [5:0] ver;
    logic [15:0] junk;
    int cap;
    int need;
    int rand_items;
    int msg_no;
    int r;
    bit short_fin;
    msg_shape_t shape;

    rst = 1'b1;
    push = 1'b0;
    kind = KIND_SEGMENT;
    value = 16'h0000;
    cfg_valid = 1'b0;
    cfg_index = REG_SYMBOL_VERSION;
    cfg_data = 16'h0000;

    // Directed rows; typed results are read straight off the packing rules
    dir_rows[0] = '{OP_ITEM, KIND_SEGMENT, 16'h00FF, 1'b1, '{8'h4F, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[1] = '{OP_ITEM, KIND_DATA, 16'h0000, 1'b1, '{8'hF0, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[2] = '{OP_ITEM, KIND_DATA, 16'h00FF, 1'b1, '{8'h0F, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[3] = '{OP_ITEM, KIND_DATA, 16'hFFA5, 1'b0, '0};
    dir_rows[4] = '{OP_ITEM, KIND_FINALIZE, 16'hFFFF, 1'b1, '{8'h50, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[5] = '{OP_ITEM, KIND_PAD, 16'h0000, 1'b1, '{PAD_FIRST, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[6] = '{OP_ITEM, KIND_PAD, 16'hFFFF, 1'b1, '{PAD_SECOND, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[7] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b1, '{8'h00, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[8] = '{OP_ITEM, KIND_PAD, 16'h1234, 1'b1, '{PAD_FIRST, 1'b1, 1'b1, STATUS_OK}};
    // Header, then a pad that lands off the byte boundary
    dir_rows[9] = '{OP_ITEM, KIND_SEGMENT, 16'h1234, 1'b0, '0};
    dir_rows[10] = '{OP_ITEM, KIND_PAD, 16'h0000, 1'b0, '0};
    dir_rows[11] = '{OP_ITEM, KIND_DATA, 16'h005A, 1'b0, '0};
    dir_rows[12] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b0, '0};
    // Largest capacity, wide count field, out-of-range versions
    dir_rows[13] = '{OP_CFG, REG_CAPACITY_BYTES, 16'hFFFF, 1'b0, '0};
    dir_rows[14] = '{OP_CFG, REG_SYMBOL_VERSION, 16'h000A, 1'b0, '0};
    dir_rows[15] = '{OP_ITEM, KIND_SEGMENT, 16'hABCD, 1'b0, '0};
    dir_rows[16] = '{OP_CFG, REG_SYMBOL_VERSION, 16'hFFFF, 1'b0, '0};
    dir_rows[17] = '{OP_ITEM, KIND_SEGMENT, 16'hFFFF, 1'b0, '0};
    dir_rows[18] = '{OP_CFG, REG_SYMBOL_VERSION, 16'hFFC0, 1'b0, '0};
    dir_rows[19] = '{OP_ITEM, KIND_SEGMENT, 16'h0000, 1'b0, '0};
    dir_rows[20] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b0, '0};
    // Fill to capacity, then a terminator that no longer fits
    dir_rows[21] = '{OP_CAP_REL, REG_CAPACITY_BYTES, 16'd1, 1'b0, '0};
    dir_rows[22] = '{OP_ITEM, KIND_DATA, 16'h003C, 1'b1, '{8'h3C, 1'b1, 1'b1, STATUS_CAPACITY}};
    dir_rows[23] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b1,
                     '{8'h00, 1'b0, 1'b1, STATUS_CAPACITY}};
    // Zero capacity: the terminator is dropped without flagging overflow
    dir_rows[24] = '{OP_CFG, REG_CAPACITY_BYTES, 16'hF000, 1'b0, '0};
    dir_rows[25] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b1,
                     '{8'h00, 1'b0, 1'b1, STATUS_CAPACITY}};
    dir_rows[26] = '{OP_CAP_REL, REG_CAPACITY_BYTES, 16'd2, 1'b0, '0};
    dir_rows[27] = '{OP_ITEM, KIND_DATA, 16'h0081, 1'b1, '{8'h81, 1'b1, 1'b1, STATUS_OK}};
    dir_rows[28] = '{OP_ITEM, KIND_FINALIZE, 16'h0000, 1'b1,
                     '{8'h00, 1'b1, 1'b1, STATUS_CAPACITY}};

    // Model state after reset
    sym_version = VERSION_RESET;
    cap_words = CAPACITY_RESET;
    acc_bits = 8'h00;
    acc_count = 3'd0;
    words_done = 12'd0;
    pad_phase = 1'b0;
    dropped_flag = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        OP_ITEM: begin
          send_item(dir_rows[i].sel, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
          n_directed++;
        end
        OP_CFG: write_reg(dir_rows[i].sel, dir_rows[i].val);
        default: write_reg(REG_CAPACITY_BYTES, {4'd0, words_done} + dir_rows[i].val);
      endcase
    end

    // Random messages; capacity is sized so nothing flagged is dropped yet
    rand_items = 0;
    msg_no = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0: ver = 6'd0;
        1: ver = 6'd9;
        2: ver = WIDE_COUNT_VERSION;
        3: ver = 6'd63;
        4: ver = 6'd40;
        default: ver = 6'($urandom_range(0, 63));
      endcase
      junk = rand_word();
      write_reg(REG_SYMBOL_VERSION, {junk[15:6], ver});
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_3 : REG_SPARE_2, rand_word());
      r = $urandom_range(0, 9);
      if (r < 6) shape = SHAPE_PLAIN;
      else if (r == 6) shape = SHAPE_HEADLESS;
      else if (r == 7) shape = SHAPE_NOISE;
      else shape = SHAPE_MIDPAD;
      build_message((msg_no == 2) ? SHAPE_PLAIN : shape, (msg_no == 2) ? 20 : -1);
      short_fin = (msg.size() > 0) && (msg[msg.size() - 1].k == KIND_FINALIZE) &&
                  ($urandom_range(0, 4) == 0);
      need = bytes_for_message(short_fin);
      r = $urandom_range(0, 7);
      if (short_fin || r > 1) cap = words_done + need;
      else if (r == 0) cap = MAX_CODEWORDS;
      else cap = words_done + need + $urandom_range(1, 5);
      junk = rand_word();
      write_reg(REG_CAPACITY_BYTES, {junk[15:12], cap[11:0]});
      // Long receiver hold while the sender keeps offering
      if (msg_no == 2) hold_req_count++;
      send_message();
      rand_items += msg.size();
      msg_no++;
    end

    // Overflow: capacity just above the written count, then below it, then zero, then the largest
    write_reg(REG_CAPACITY_BYTES, {4'd0, words_done} + 16'd2);
    build_message(SHAPE_PLAIN, 6);
    send_message();
    write_reg(REG_CAPACITY_BYTES, {4'd0, words_done >> 1});
    build_message(SHAPE_NOISE, -1);
    send_message();
    write_reg(REG_CAPACITY_BYTES, 16'h0000);
    build_message(SHAPE_NOISE, -1);
    send_message();
    write_reg(REG_SYMBOL_VERSION, 16'd41);
    write_reg(REG_CAPACITY_BYTES, {4'd0, MAX_CODEWORDS});
    build_message(SHAPE_PLAIN, -1);
    send_message();

    // Drain and give stray results a chance to show up
    settle_block();
    repeat (8) @(posedge clk);

    $display("Covered %0d items (%0d directed), %0d results, %0d register writes.",
             n_items, n_directed, n_results, n_writes);
    $display("Results: %0d at capacity, %0d after overflow, %0d without codeword; %0d multi.",
             n_cap_status, n_ovf_status, n_blank, n_multi);
    if (err_count == 0) begin
      $display("qr_byte_mode_segment_packer_unit verification clean");
    end else begin
      $display("qr_byte_mode_segment_packer_unit verification failed");
    end
    $finish;
  end

endmodule
